@@ src/press_classified_lamp_blinker_core_assert.svh @@
// assertion macros used by the lamp blinker state module
`ifndef PRESS_CLASSIFIED_LAMP_BLINKER_CORE_ASSERT_SVH
`define PRESS_CLASSIFIED_LAMP_BLINKER_CORE_ASSERT_SVH

// condition must hold at every clock edge out of reset
`define PLB_ASSERT_ALWAYS(label, cond) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond)) \
        else $error("plb invariant violated");

// consequence must hold in the cycle after the trigger
`define PLB_ASSERT_NEXT(label, trig, cond) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (trig) |=> (cond)) \
        else $error("plb next-cycle check failed");

`endif

@@ src/plb_pkg.sv @@
// types, constants and codes of the press classified lamp blinker
`timescale 1ns / 1ps
`default_nettype none

package plb_pkg;

    localparam int REFRESH_TICKS = 1000;
    localparam int FAST_TICKS    = 2000;
    localparam int SLOW_TICKS    = 4000;
    localparam int CHANNELS      = 4;

    localparam int TICK_W   = 12;
    localparam int HOLD_W   = 16;
    localparam int CH_W     = 2;
    localparam int LAMPS    = 4;
    localparam int CNT_W    = 2;
    localparam int PADDR_W  = 3;
    localparam int PDATA_W  = 32;

    typedef enum logic [1:0] {
        MODE_ON    = 2'd0,
        MODE_OFF   = 2'd1,
        MODE_SHORT = 2'd2,
        MODE_LONG  = 2'd3
    } mode_t;

    typedef enum logic {
        ACT_PRESS = 1'b0,
        ACT_TICK  = 1'b1
    } act_t;

    typedef enum logic {
        REG_SHORT_THR = 1'b0,
        REG_LONG_THR  = 1'b1
    } reg_idx_t;

    typedef struct packed {
        logic [HOLD_W-1:0] short_thr;
        logic [HOLD_W-1:0] long_thr;
    } cfg_t;

    typedef struct packed {
        act_t              action;
        logic [CH_W-1:0]   channel;
        logic [HOLD_W-1:0] hold_ms;
    } item_t;

    typedef struct packed {
        logic [LAMPS-1:0] lamps_lit;
        mode_t            right_mode;
        mode_t            left_mode;
        mode_t            front_mode;
        mode_t            back_mode;
    } result_t;

endpackage

`default_nettype wire

@@ src/plb_if.sv @@
// handshake interfaces for the press/tick items and the lamp results
`timescale 1ns / 1ps
`default_nettype none

interface plb_item_if;
    logic        valid;
    logic        ready;
    logic        action;
    logic [1:0]  channel;
    logic [15:0] hold_ms;

    modport source (output valid, output action, output channel, output hold_ms, input ready);
    modport sink   (input valid, input action, input channel, input hold_ms, output ready);
endinterface

interface plb_result_if;
    logic       valid;
    logic       ready;
    logic [3:0] lamps_lit;
    logic [1:0] right_mode;
    logic [1:0] left_mode;
    logic [1:0] front_mode;
    logic [1:0] back_mode;

    modport source (output valid, output lamps_lit, output right_mode, output left_mode,
                    output front_mode, output back_mode, input ready);
    modport sink   (input valid, input lamps_lit, input right_mode, input left_mode,
                    input front_mode, input back_mode, output ready);
endinterface

`default_nettype wire

@@ src/plb_cfg_regs.sv @@
// apb threshold registers
`timescale 1ns / 1ps
`default_nettype none

module plb_cfg_regs (
    input  wire logic                         clk,
    input  wire logic                         rst_n,
    input  wire logic                         psel,
    input  wire logic                         penable,
    input  wire logic                         pwrite,
    input  wire logic [plb_pkg::PADDR_W-1:0]  paddr,
    input  wire logic [plb_pkg::PDATA_W-1:0]  pwdata,
    output logic      [plb_pkg::PDATA_W-1:0]  prdata,
    output logic                              pready,
    output plb_pkg::cfg_t                     cfg
);

    logic [plb_pkg::HOLD_W-1:0] short_thr_reg;
    logic [plb_pkg::HOLD_W-1:0] long_thr_reg;
    plb_pkg::reg_idx_t          idx;
    logic                       wr_en;

    assign idx    = plb_pkg::reg_idx_t'(paddr[2]);
    assign wr_en  = psel && penable && pwrite;
    assign pready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            short_thr_reg <= plb_pkg::HOLD_W'(150);
            long_thr_reg  <= plb_pkg::HOLD_W'(500);
        end
        else if (wr_en)
        begin
            unique case (idx)
                plb_pkg::REG_SHORT_THR: short_thr_reg <= pwdata[plb_pkg::HOLD_W-1:0];
                plb_pkg::REG_LONG_THR:  long_thr_reg  <= pwdata[plb_pkg::HOLD_W-1:0];
            endcase
        end
    end

    always_comb
    begin
        prdata = '0;
        unique case (idx)
            plb_pkg::REG_SHORT_THR: prdata[plb_pkg::HOLD_W-1:0] = short_thr_reg;
            plb_pkg::REG_LONG_THR:  prdata[plb_pkg::HOLD_W-1:0] = long_thr_reg;
        endcase
    end

    assign cfg.short_thr = short_thr_reg;
    assign cfg.long_thr  = long_thr_reg;

endmodule

`default_nettype wire

@@ src/plb_lamp_state.sv @@
// per-channel mode, press counters, blink flags, lamp levels and tick counters
`timescale 1ns / 1ps
`default_nettype none

module plb_lamp_state (
    input  wire logic            clk,
    input  wire logic            rst_n,
    input  wire logic            upd_en,
    input  wire plb_pkg::item_t  item,
    input  wire plb_pkg::cfg_t   cfg,
    output plb_pkg::result_t     result_next
);

    plb_pkg::mode_t             mode_reg  [plb_pkg::CHANNELS];
    plb_pkg::mode_t             mode_next [plb_pkg::CHANNELS];
    logic [plb_pkg::CNT_W-1:0]  cnt_reg   [plb_pkg::CHANNELS];
    logic [plb_pkg::CNT_W-1:0]  cnt_next  [plb_pkg::CHANNELS];
    logic [plb_pkg::CHANNELS-1:0] slow_reg, slow_next;
    logic [plb_pkg::CHANNELS-1:0] fast_reg, fast_next;
    logic [plb_pkg::CHANNELS-1:0] lvl_reg, lvl_next;
    logic [plb_pkg::TICK_W-1:0] tick_reg, tick_next;
    logic [plb_pkg::TICK_W-1:0] refresh_reg, refresh_next;
    logic [plb_pkg::TICK_W-1:0] fast_cnt_reg, fast_cnt_next;
    logic [plb_pkg::TICK_W-1:0] tick_inc, refresh_inc, fast_inc;
    logic                       is_tick, is_press, is_hold, is_long;
    logic                       refresh_hit, fast_hit, slow_hit;
    logic                       cnt_any;
    plb_pkg::mode_t             out_mode [plb_pkg::LAMPS];
    logic [plb_pkg::LAMPS-1:0]  out_lit;

    assign is_tick  = (item.action == plb_pkg::ACT_TICK);
    assign is_press = !is_tick && (item.hold_ms < cfg.short_thr);
    assign is_hold  = !is_tick && !is_press;
    assign is_long  = !(item.hold_ms < cfg.long_thr);

    // tick phases kept as running remainders, all restarted when the slow period wraps
    assign tick_inc    = tick_reg + 1'b1;
    assign refresh_inc = refresh_reg + 1'b1;
    assign fast_inc    = fast_cnt_reg + 1'b1;
    assign slow_hit    = (tick_inc == plb_pkg::TICK_W'(plb_pkg::SLOW_TICKS));
    assign refresh_hit = slow_hit || (refresh_inc == plb_pkg::TICK_W'(plb_pkg::REFRESH_TICKS));
    assign fast_hit    = slow_hit || (fast_inc == plb_pkg::TICK_W'(plb_pkg::FAST_TICKS));

    always_comb
    begin
        tick_next     = tick_reg;
        refresh_next  = refresh_reg;
        fast_cnt_next = fast_cnt_reg;
        if (is_tick)
        begin
            tick_next     = slow_hit ? '0 : tick_inc;
            refresh_next  = refresh_hit ? '0 : refresh_inc;
            fast_cnt_next = fast_hit ? '0 : fast_inc;
        end
    end

    always_comb
    begin
        slow_next = slow_reg;
        fast_next = fast_reg;
        lvl_next  = lvl_reg;
        for (int i = 0; i < plb_pkg::CHANNELS; i++)
        begin
            mode_next[i] = mode_reg[i];
            cnt_next[i]  = cnt_reg[i];
            if (is_press && ({2'b00, item.channel} == 4'(i)))
            begin
                if (cnt_reg[i] == '0)
                begin
                    mode_next[i] = plb_pkg::MODE_ON;
                    // first press after a hold skips the ignored press
                    cnt_next[i]  = (mode_reg[i] == plb_pkg::MODE_SHORT ||
                                    mode_reg[i] == plb_pkg::MODE_LONG) ? 2'd2 : 2'd1;
                end
                else if (cnt_reg[i] == 2'd1)
                begin
                    cnt_next[i] = 2'd2;
                end
                else
                begin
                    mode_next[i] = plb_pkg::MODE_OFF;
                    cnt_next[i]  = '0;
                end
            end
            if (is_hold)
            begin
                cnt_next[i] = '0;
                if ({2'b00, item.channel} == 4'(i))
                    mode_next[i] = is_long ? plb_pkg::MODE_LONG : plb_pkg::MODE_SHORT;
            end
            if (is_tick)
            begin
                if (refresh_hit)
                begin
                    slow_next[i] = (mode_reg[i] == plb_pkg::MODE_SHORT);
                    fast_next[i] = (mode_reg[i] == plb_pkg::MODE_LONG);
                    if (mode_reg[i] == plb_pkg::MODE_ON)
                        lvl_next[i] = 1'b1;
                    else if (mode_reg[i] == plb_pkg::MODE_OFF)
                        lvl_next[i] = 1'b0;
                end
                if (fast_hit && fast_next[i])
                    lvl_next[i] = !lvl_next[i];
                if (slow_hit && slow_next[i])
                    lvl_next[i] = !lvl_next[i];
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < plb_pkg::CHANNELS; i++)
            begin
                mode_reg[i] <= plb_pkg::MODE_OFF;
                cnt_reg[i]  <= '0;
            end
            slow_reg     <= '0;
            fast_reg     <= '0;
            lvl_reg      <= '0;
            tick_reg     <= '0;
            refresh_reg  <= '0;
            fast_cnt_reg <= '0;
        end
        else if (upd_en)
        begin
            for (int i = 0; i < plb_pkg::CHANNELS; i++)
            begin
                mode_reg[i] <= mode_next[i];
                cnt_reg[i]  <= cnt_next[i];
            end
            slow_reg     <= slow_next;
            fast_reg     <= fast_next;
            lvl_reg      <= lvl_next;
            tick_reg     <= tick_next;
            refresh_reg  <= refresh_next;
            fast_cnt_reg <= fast_cnt_next;
        end
    end

    // absent channels read as off and unlit
    for (genvar j = 0; j < plb_pkg::LAMPS; j++)
    begin : g_out
        if (j < plb_pkg::CHANNELS)
        begin : g_present
            assign out_mode[j] = mode_next[j];
            assign out_lit[j]  = lvl_next[j];
        end
        else
        begin : g_absent
            assign out_mode[j] = plb_pkg::MODE_OFF;
            assign out_lit[j]  = 1'b0;
        end
    end

    assign result_next.lamps_lit  = out_lit;
    assign result_next.right_mode = out_mode[0];
    assign result_next.left_mode  = out_mode[1];
    assign result_next.front_mode = out_mode[2];
    assign result_next.back_mode  = out_mode[3];

    always_comb
    begin
        cnt_any = 1'b0;
        for (int i = 0; i < plb_pkg::CHANNELS; i++)
            cnt_any = cnt_any | (|cnt_reg[i]);
    end

`include "press_classified_lamp_blinker_core_assert.svh"

    `PLB_ASSERT_ALWAYS(a_blink_exclusive, (slow_reg & fast_reg) == '0)
    `PLB_ASSERT_ALWAYS(a_tick_in_range, tick_reg < plb_pkg::TICK_W'(plb_pkg::SLOW_TICKS))
    `PLB_ASSERT_ALWAYS(a_phase_aligned, tick_reg != '0 || (refresh_reg == '0 && fast_cnt_reg == '0))
    `PLB_ASSERT_NEXT(a_hold_clears_counts, upd_en && is_hold, !cnt_any)

endmodule

`default_nettype wire

@@ src/press_classified_lamp_blinker_core.sv @@
// top level of the press classified lamp blinker
// usage:
//   item_in carries one transaction per key press (action 0, channel, hold_ms) or
//   timer tick (action 1); result_out returns exactly one transaction per input
//   transaction, in order: the lamp bits and the four channel modes after the update.
//   the apb port holds the short and long hold thresholds, at byte addresses 0 and 4;
//   write them only while no transaction is in flight.
// pipeline and throughput:
//   an accepted transaction lands in the input stage and is applied to the channel
//   state when it advances, which also loads the result register and raises
//   result_out.valid. one transaction per cycle is sustained while result_out is
//   ready; the single state update per cycle between the input stage and the result
//   register sets that figure.
// reset:
//   all channels off with counters, flags, lamps and the tick phase cleared;
//   thresholds return to 150 and 500 ms.
// stall:
//   while result_out is held, the result register keeps its transaction and the input
//   stage can still take one more; item_in.ready then drops until result_out drains.
`timescale 1ns / 1ps
`default_nettype none

module press_classified_lamp_blinker_core (
    input  wire logic                         clk,
    input  wire logic                         rst_n,
    input  wire logic                         psel,
    input  wire logic                         penable,
    input  wire logic                         pwrite,
    input  wire logic [plb_pkg::PADDR_W-1:0]  paddr,
    input  wire logic [plb_pkg::PDATA_W-1:0]  pwdata,
    output logic      [plb_pkg::PDATA_W-1:0]  prdata,
    output logic                              pready,
    plb_item_if.sink                          item_in,
    plb_result_if.source                      result_out
);

    plb_pkg::cfg_t    cfg;
    plb_pkg::item_t   stg_item_reg;
    logic             stg_valid_reg;
    plb_pkg::result_t res_next;
    plb_pkg::result_t res_reg;
    logic             out_valid_reg;
    logic             advance;

    plb_cfg_regs u_cfg (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    // the staged transaction moves on whenever the result register is free or draining
    assign advance       = stg_valid_reg && (!out_valid_reg || result_out.ready);
    assign item_in.ready = !stg_valid_reg || advance;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            stg_valid_reg <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (item_in.ready)
                stg_valid_reg <= item_in.valid;
            if (advance)
                out_valid_reg <= 1'b1;
            else if (result_out.ready)
                out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (item_in.ready && item_in.valid)
        begin
            stg_item_reg.action  <= plb_pkg::act_t'(item_in.action);
            stg_item_reg.channel <= item_in.channel;
            stg_item_reg.hold_ms <= item_in.hold_ms;
        end
        if (advance)
            res_reg <= res_next;
    end

    plb_lamp_state u_state (
        .clk         (clk),
        .rst_n       (rst_n),
        .upd_en      (advance),
        .item        (stg_item_reg),
        .cfg         (cfg),
        .result_next (res_next)
    );

    assign result_out.valid      = out_valid_reg;
    assign result_out.lamps_lit  = res_reg.lamps_lit;
    assign result_out.right_mode = res_reg.right_mode;
    assign result_out.left_mode  = res_reg.left_mode;
    assign result_out.front_mode = res_reg.front_mode;
    assign result_out.back_mode  = res_reg.back_mode;

endmodule

`default_nettype wire
